// ===== rtl/core/ecd_pkg.sv =====
// Shared types and constants for the environment condition detector.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ecd_pkg;

   // Field widths
   localparam int COLOR_W = 8;
   localparam int COORD_W = 12;
   localparam int HDOP_W  = 14;
   localparam int SATS_W  = 6;
   localparam int LEVEL_W = 8;
   localparam int STATE_W = 2;
   localparam int CONF_W  = 9;
   localparam int LUMA_W  = 16;
   localparam int SUM_W   = 36;
   localparam int COUNT_W = 21;
   localparam int TC_W    = LEVEL_W + COUNT_W;
   localparam int NUM_W   = TC_W + 8;
   localparam int DEN_W   = TC_W;

   // Stream and CSR port widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Frame sampling
   localparam int MAX_FRAME_WIDTH  = 4096;
   localparam int MAX_FRAME_HEIGHT = 4096;
   localparam int SAMPLE_STEP      = 4;

   // Q8 luma weights
   localparam logic [LUMA_W-1:0] LUMA_R = 16'd77;
   localparam logic [LUMA_W-1:0] LUMA_G = 16'd150;
   localparam logic [LUMA_W-1:0] LUMA_B = 16'd29;

   localparam logic [CONF_W-1:0] CONF_FULL = 9'd256;

   // Environment states
   localparam logic [STATE_W-1:0] ENV_NORMAL     = 2'd0;
   localparam logic [STATE_W-1:0] ENV_LOW_LIGHT  = 2'd1;
   localparam logic [STATE_W-1:0] ENV_GPS_DENIED = 2'd2;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HDOP_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SATS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CONF  = 3'd4;

   // Reset values of the CSRs
   localparam logic [LEVEL_W-1:0] RST_LOW_LIGHT  = 8'd50;
   localparam logic [HDOP_W-1:0]  RST_HDOP_LIMIT = 14'd500;
   localparam logic [SATS_W-1:0]  RST_MIN_SATS   = 6'd6;

   // Divider request / response
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CONF_W-1:0] quot;
   } div_rsp_type;

   // Latched input word
   typedef struct packed {
      logic               kind;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               eof;
      logic [HDOP_W-1:0]  hdop;
      logic [SATS_W-1:0]  sats;
   } in_word_type;

endpackage

`default_nettype wire

// ===== rtl/core/ecd_div.sv =====
// Shared restoring divider with Q8 clamp: quot = min(num / den, 256).
// Depends on ecd_pkg. Caller guarantees num < 512 * den unless clamped.
`default_nettype none

module ecd_div
   import ecd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [CONF_W-1:0] quot_ff, quot_in;
   logic              ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd8;
         rem_in  = req.num;
         dsh_in  = {req.den, 8'b0};
         quot_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd8) begin
            // top step only detects a quotient of 256 or more
            if (ge) begin
               quot_in = CONF_FULL;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else if (ge) begin
            rem_in = rem_ff - dsh_ff;
            quot_in[cnt_ff[2:0]] = 1'b1;
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/environment_condition_detector.sv =====
// Environment condition detector top level: sequencer, frame accumulator, CSRs, output register.
// One word at a time: req_tready is high only in IDLE. A plain pixel passes LUMA and ACCUM;
// a frame end adds JMUL and, for a non-empty frame, JCMP; a GNSS sample passes GNSS. JDIV, GDIV1
// and GDIV2 wait on the shared divider, which stops early when it clamps at 256; a state change
// ends in EMIT. A stalled result register holds the sequencer in EMIT.
// Synchronous active-high reset: state normal, confidence 256, sums cleared, CSRs to defaults.
`default_nettype none

module environment_condition_detector
   import ecd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata from bit 0: red, green, blue, pixel_col, pixel_row, hdop_centi, satellites_used, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: kind (0 pixel, 1 GNSS sample)
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,   // end_of_frame
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata from bit 0: env_state, confidence_q8, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // CSR write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LUMA  = 4'd1;
   localparam logic [3:0] ST_ACCUM = 4'd2;
   localparam logic [3:0] ST_JMUL  = 4'd3;
   localparam logic [3:0] ST_JCMP  = 4'd4;
   localparam logic [3:0] ST_JDIV  = 4'd5;
   localparam logic [3:0] ST_GNSS  = 4'd6;
   localparam logic [3:0] ST_GDIV1 = 4'd7;
   localparam logic [3:0] ST_GDIV2 = 4'd8;
   localparam logic [3:0] ST_EMIT  = 4'd9;

   logic [3:0]         state_ff, state_in;
   in_word_type        word_ff;

   // CSRs
   logic [LEVEL_W-1:0] level_ff;
   logic [HDOP_W-1:0]  hlim_ff;
   logic [SATS_W-1:0]  msat_ff;

   // Environment state
   logic [STATE_W-1:0] cur_state_ff, cur_state_in;
   logic [CONF_W-1:0]  cur_conf_ff, cur_conf_in;

   // Frame accumulator
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LUMA_W-1:0]  luma_ff;
   logic               smp_ff;
   logic [TC_W-1:0]    tc_ff;

   // GNSS working registers
   logic               bad_hdop_ff, bad_sats_ff;
   logic [CONF_W-1:0]  hr_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               in_acc;
   logic               csr_we;
   logic               sampled;
   logic [LUMA_W-1:0]  luma;
   logic [SUM_W:0]     sum_ext;
   logic [NUM_W-1:0]   tc_q8;
   logic               is_dark;
   logic               bad_hdop, bad_sats;
   logic               go_dark, go_denied;
   logic [CONF_W-1:0]  sr;

   assign req_tready = state_ff == ST_IDLE;
   assign in_acc     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_we     = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sample only in-frame pixels on the sampling grid
   assign sampled = (int'(word_ff.col) < MAX_FRAME_WIDTH)
                 && (int'(word_ff.row) < MAX_FRAME_HEIGHT)
                 && ((word_ff.col % COORD_W'(SAMPLE_STEP)) == '0)
                 && ((word_ff.row % COORD_W'(SAMPLE_STEP)) == '0);

   assign luma = LUMA_R * LUMA_W'(word_ff.red)
               + LUMA_G * LUMA_W'(word_ff.green)
               + LUMA_B * LUMA_W'(word_ff.blue);

   assign sum_ext = {1'b0, sum_ff} + (SUM_W + 1)'(luma_ff);

   // Frame judgement: mean below level <=> sum < 256 * level * count
   assign tc_q8   = {tc_ff, 8'b0};
   assign is_dark = (level_ff != '0) && ({1'b0, sum_ff} < tc_q8);
   assign go_dark = is_dark && (cur_state_ff != ENV_LOW_LIGHT);

   assign bad_hdop  = word_ff.hdop > hlim_ff;
   assign bad_sats  = word_ff.sats < msat_ff;
   assign go_denied = (bad_hdop || bad_sats) && (cur_state_ff != ENV_GPS_DENIED);

   assign sr = bad_sats_ff ? div_rsp.quot : '0;

   // Launch the shared divider
   always_comb begin
      div_req = '0;
      case (state_ff)
         ST_JCMP: begin
            div_req.start = go_dark;
            div_req.num   = tc_q8 - {1'b0, sum_ff};
            div_req.den   = tc_ff;
         end
         ST_GNSS: begin
            div_req.start = go_denied;
            div_req.num   = NUM_W'({word_ff.hdop - hlim_ff, 8'b0});
            div_req.den   = DEN_W'(hlim_ff);
         end
         ST_GDIV1: begin
            div_req.start = div_rsp.done;
            div_req.num   = NUM_W'({msat_ff - word_ff.sats, 8'b0});
            div_req.den   = DEN_W'(msat_ff);
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   ecd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_state_in = cur_state_ff;
      cur_conf_in  = cur_conf_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               state_in = req_tuser ? ST_GNSS : ST_LUMA;
            end
         end
         ST_LUMA: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // saturate sum and count at their widths
            if (smp_ff) begin
               sum_in = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            state_in = word_ff.eof ? ST_JMUL : ST_IDLE;
         end
         ST_JMUL: begin
            // empty frame judges nothing, only clears
            if (count_ff == '0) begin
               sum_in   = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_JCMP;
            end
         end
         ST_JCMP: begin
            sum_in   = '0;
            count_in = '0;
            if (go_dark) begin
               state_in = ST_JDIV;
            end else if (!is_dark && cur_state_ff == ENV_LOW_LIGHT) begin
               cur_state_in = ENV_NORMAL;
               cur_conf_in  = CONF_FULL;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_JDIV: begin
            if (div_rsp.done) begin
               cur_state_in = ENV_LOW_LIGHT;
               cur_conf_in  = div_rsp.quot;
               state_in     = ST_EMIT;
            end
         end
         ST_GNSS: begin
            if (go_denied) begin
               state_in = ST_GDIV1;
            end else if (!bad_hdop && !bad_sats && cur_state_ff == ENV_GPS_DENIED) begin
               cur_state_in = ENV_NORMAL;
               cur_conf_in  = CONF_FULL;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GDIV1: begin
            if (div_rsp.done) begin
               state_in = ST_GDIV2;
            end
         end
         ST_GDIV2: begin
            if (div_rsp.done) begin
               cur_state_in = ENV_GPS_DENIED;
               cur_conf_in  = (hr_ff > sr) ? hr_ff : sr;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({cur_conf_ff, cur_state_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // CSR writes must arrive only while the block is idle; the block itself does not enforce it
      if (csr_we && csr_index == CSR_START_STATE) begin
         cur_state_in = csr_data[STATE_W-1:0];
      end
      if (csr_we && csr_index == CSR_START_CONF) begin
         cur_conf_in = (csr_data[CONF_W-1:0] > CONF_FULL) ? CONF_FULL : csr_data[CONF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_state_ff <= ENV_NORMAL;
         cur_conf_ff  <= CONF_FULL;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= RST_LOW_LIGHT;
         hlim_ff      <= RST_HDOP_LIMIT;
         msat_ff      <= RST_MIN_SATS;
      end else begin
         state_ff     <= state_in;
         cur_state_ff <= cur_state_in;
         cur_conf_ff  <= cur_conf_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_LOW_LIGHT) begin
            level_ff <= csr_data[LEVEL_W-1:0];
         end
         if (csr_we && csr_index == CSR_HDOP_LIMIT) begin
            hlim_ff <= csr_data[HDOP_W-1:0];
         end
         if (csr_we && csr_index == CSR_MIN_SATS) begin
            msat_ff <= csr_data[SATS_W-1:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (in_acc) begin
         word_ff.kind  <= req_tuser;
         word_ff.red   <= req_tdata[7:0];
         word_ff.green <= req_tdata[15:8];
         word_ff.blue  <= req_tdata[23:16];
         word_ff.col   <= req_tdata[35:24];
         word_ff.row   <= req_tdata[47:36];
         word_ff.eof   <= req_tlast;
         word_ff.hdop  <= req_tdata[61:48];
         word_ff.sats  <= req_tdata[67:62];
      end
      if (state_ff == ST_LUMA) begin
         luma_ff <= luma;
         smp_ff  <= sampled;
      end
      if (state_ff == ST_JMUL) begin
         tc_ff <= TC_W'(level_ff) * TC_W'(count_ff);
      end
      if (state_ff == ST_GNSS) begin
         bad_hdop_ff <= bad_hdop;
         bad_sats_ff <= bad_sats;
      end
      if (state_ff == ST_GDIV1 && div_rsp.done) begin
         hr_ff <= bad_hdop_ff ? div_rsp.quot : '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ecd_checker.sv =====
// Port-level checker for the environment condition detector, bound to the top level.
// Depends on ecd_pkg for field widths and state codes.
`default_nettype none

module ecd_checker
   import ecd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on back-to-back cycles");

   // confidence never exceeds 1.0
   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:2] <= CONF_FULL)
      else $error("confidence above 256");

   // a return to normal always carries full confidence
   a_normal_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ENV_NORMAL |-> rsp_tdata[10:2] == CONF_FULL)
      else $error("normal state without full confidence");

   // reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind environment_condition_detector ecd_checker u_ecd_checker (.*);

`default_nettype wire
